// File: hw/rtl/bmap_pkg.sv
// Shared constants, item types and control structs for the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package bmap_pkg;

   // Map geometry
   localparam int MAP_BITS   = 1024;
   localparam int WORD_BITS  = 32;
   localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int WADDR_W    = $clog2(NUM_WORDS);

   // Field widths
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int END_W  = CNT_W + 1;
   localparam int CSR_W  = 11;

   // Bit count inside one word (0..WORD_BITS) and index of a doubling level
   localparam int POS_W = $clog2(WORD_BITS + 1);
   localparam int LVL_W = $clog2(WORD_SHIFT + 1);

   localparam logic [CSR_W-1:0] BITS_IN_USE_RESET = CSR_W'(1024);

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_READ       = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND_FIRST = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND_RUN   = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  bit_index;
      logic [CNT_W-1:0]  run_count;
      logic              wanted_value;
   } bmap_req_type;

   typedef struct packed {
      logic             bit_read;
      logic             found;
      logic [IDX_W-1:0] found_index;
   } bmap_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic load_rsp;
   } bmap_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skip;
      logic last;
   } bmap_sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/bmap_ctrl.sv
// Sequencing state machine for the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

module bmap_ctrl import bmap_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire bmap_sts_type sts,
   output bmap_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = sts.skip ? ST_FINISH : ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bmap_dpath.sv
// Bitmap store, word walker, run search and write-mask logic.
`timescale 1ns / 1ps
`default_nettype none

module bmap_dpath import bmap_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bmap_req_type     req_data,
   input  wire logic             csr_write,
   input  wire logic [CSR_W-1:0] csr_data,
   input  wire bmap_cmd_type     cmd,
   output bmap_sts_type          sts,
   output bmap_rsp_type          rsp_data
);

   // Storage
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] vld_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rvld_ff;

   bmap_req_type         req_ff;
   logic [CSR_W-1:0]     bits_in_use_ff;
   logic [WADDR_W-1:0]   w_ff;
   logic [CNT_W-1:0]     carry_ff;
   logic                 res_bit_ff;
   logic                 res_found_ff;
   logic [IDX_W-1:0]     res_idx_ff;
   bmap_rsp_type         rsp_ff;

   // Item decode
   logic                 is_search;
   logic [CNT_W-1:0]     limit;
   logic [CNT_W-1:0]     len;
   logic [WADDR_W-1:0]   first_w;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WADDR_W-1:0]   w_next;
   logic [WORD_BITS-1:0] word;
   logic                 triv_found;

   // Search
   logic [CNT_W-1:0]      lm1;
   logic [WADDR_W-1:0]    last_w;
   logic [WORD_SHIFT-1:0] lim_lo;
   logic [WORD_BITS-1:0]  lmask;
   logic [WORD_BITS-1:0]  match;
   logic [POS_W-1:0]      tz;
   logic [POS_W-1:0]      lead;
   logic [WORD_BITS-1:0]  pw [WORD_SHIFT+1];
   logic [LVL_W-1:0]      lvl;
   logic [POS_W-1:0]      len_lo;
   logic [POS_W-1:0]      sh;
   logic [WORD_BITS-1:0]  win;
   logic [POS_W-1:0]      win_pos;
   logic [CNT_W:0]        sum_a;
   logic                  hit_a;
   logic                  hit_b;
   logic                  hit;
   logic [CNT_W-1:0]      base;
   logic [CNT_W-1:0]      hit_idx;
   logic [CNT_W-1:0]      carry_next;

   // Write run
   logic [END_W-1:0]      end_pos;
   logic [END_W-1:0]      next_base;
   logic [WORD_SHIFT-1:0] lower;
   logic [WORD_BITS-1:0]  wmask;
   logic [WORD_BITS-1:0]  wdata;
   logic                  wr_en;

   // Decode of the held item
   always_comb begin
      is_search  = (req_ff.func == FUNC_FIND_FIRST) || (req_ff.func == FUNC_FIND_RUN);
      limit      = (bits_in_use_ff > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : bits_in_use_ff;
      len        = (req_ff.func == FUNC_FIND_FIRST) ? CNT_W'(1) : req_ff.run_count;
      first_w    = is_search ? '0 : WADDR_W'(req_ff.bit_index >> WORD_SHIFT);
      w_next     = w_ff + WADDR_W'(1);
      rd_addr    = cmd.start ? first_w : w_next;
      word       = rvld_ff ? rdata_ff : '0;
      triv_found = is_search && (limit != '0) && (len == '0);
   end

   // Search over the current word: span hit from the carried run, or a run inside the word
   always_comb begin
      lm1    = limit - CNT_W'(1);
      last_w = WADDR_W'(lm1 >> WORD_SHIFT);
      lim_lo = limit[WORD_SHIFT-1:0];
      if ((w_ff == last_w) && (lim_lo != '0)) begin
         lmask = ~({WORD_BITS{1'b1}} << lim_lo);
      end else begin
         lmask = {WORD_BITS{1'b1}};
      end
      match = (word ~^ {WORD_BITS{req_ff.wanted_value}}) & lmask;

      // lowest mismatch and length of the top run of matches
      tz = POS_W'(WORD_BITS);
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!match[b]) tz = POS_W'(b);
      end
      lead = POS_W'(WORD_BITS);
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!match[b]) lead = POS_W'(WORD_BITS - 1 - b);
      end

      // pw[j][s]: bits s .. s+2^j-1 all match
      pw[0] = match;
      for (int j = 1; j <= WORD_SHIFT; j++) begin
         pw[j] = pw[j-1] & (pw[j-1] >> (1 << (j - 1)));
      end

      // window of len bits from two overlapping power-of-two windows
      len_lo = len[POS_W-1:0];
      lvl    = '0;
      for (int j = 0; j <= WORD_SHIFT; j++) begin
         if (len_lo[j]) lvl = LVL_W'(j);
      end
      sh  = len_lo - (POS_W'(1) << lvl);
      win = pw[lvl] & (pw[lvl] >> sh);

      win_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (win[b]) win_pos = POS_W'(b);
      end

      sum_a   = {1'b0, carry_ff} + (CNT_W + 1)'(tz);
      hit_a   = sum_a >= {1'b0, len};
      hit_b   = (len <= CNT_W'(WORD_BITS)) && (win != '0);
      hit     = hit_a || hit_b;
      base    = CNT_W'(w_ff) << WORD_SHIFT;
      hit_idx = hit_a ? (base - carry_ff) : (base + CNT_W'(win_pos));

      if (&match) begin
         carry_next = carry_ff + CNT_W'(WORD_BITS);
      end else begin
         carry_next = CNT_W'(lead);
      end
   end

   // Mask of run bits that fall into the current word
   always_comb begin
      end_pos   = END_W'(req_ff.bit_index) + END_W'(req_ff.run_count);
      next_base = END_W'({1'b0, w_ff} + (WADDR_W + 1)'(1)) << WORD_SHIFT;
      lower     = (w_ff == first_w) ? req_ff.bit_index[WORD_SHIFT-1:0] : '0;
      wmask     = {WORD_BITS{1'b1}} << lower;
      if (end_pos < next_base) begin
         wmask = wmask & ~({WORD_BITS{1'b1}} << end_pos[WORD_SHIFT-1:0]);
      end
      wdata = req_ff.wanted_value ? (word | wmask) : (word & ~wmask);
      wr_en = cmd.step && (req_ff.func == FUNC_WRITE);
   end

   // Status to the controller
   always_comb begin
      case (req_ff.func)
         FUNC_READ: begin
            sts.skip = 1'b0;
            sts.last = 1'b1;
         end
         FUNC_WRITE: begin
            sts.skip = (req_ff.run_count == '0);
            sts.last = (w_ff == WADDR_W'(NUM_WORDS - 1)) || (end_pos <= next_base);
         end
         default: begin
            sts.skip = (limit == '0) || (len > limit) || (len == '0);
            sts.last = hit || (w_ff == last_w);
         end
      endcase
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= BITS_IN_USE_RESET;
      end else if (csr_write) begin
         bits_in_use_ff <= csr_data;
      end
   end

   // Word valid bits: an unwritten word reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[w_ff] <= 1'b1;
      end
   end

   // Bitmap memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[w_ff] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
      rvld_ff  <= vld_ff[rd_addr];
   end

   // Item, walker and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.start) begin
         w_ff         <= first_w;
         carry_ff     <= '0;
         res_bit_ff   <= 1'b0;
         res_found_ff <= triv_found;
         res_idx_ff   <= '0;
      end else if (cmd.step) begin
         w_ff     <= w_next;
         carry_ff <= carry_next;
         case (req_ff.func)
            FUNC_READ: begin
               res_bit_ff <= word[req_ff.bit_index[WORD_SHIFT-1:0]];
            end
            FUNC_FIND_FIRST, FUNC_FIND_RUN: begin
               if (hit) begin
                  res_found_ff <= 1'b1;
                  res_idx_ff   <= hit_idx[IDX_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_ff.bit_read    <= res_bit_ff;
         rsp_ff.found       <= res_found_ff;
         rsp_ff.found_index <= res_idx_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_allocator_unit.sv
// Top level of the bitmap allocator: controller, datapath and configuration port.
`timescale 1ns / 1ps
`default_nettype none

// Bitmap allocator over a 1024-bit map held as 32 words of 32 bits, all zero after
// reset (per-word valid bits, so no clearing pass is needed). Each item gives one
// result. The map is walked one word per cycle through the single registered read
// port of the word memory, with a write-back in the same cycle for run writes. A bit
// read steps over its single word; a run write steps over each word touched (none
// when the count is zero); a search steps over each word scanned, stopping at a hit,
// at most ceil(limit / 32) words. Searches that cannot succeed, or ask for a
// zero-length run, skip the word walk and go straight to the result.
// A new item is taken while the previous result still waits on the output.
// The bits_in_use register is written through the csr channel, which is always ready.
module bitmap_allocator_unit import bmap_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bmap_req_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bmap_rsp_type          rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_data
);

   bmap_cmd_type cmd;
   bmap_sts_type sts;

   assign csr_ready = 1'b1;

   bmap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmap_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
